// ===== src/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, angle constants and the CORDIC arctangent table for the
// quaternion to Euler angle core.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int IN_W       = 16;          // Q1.15 component
	localparam int PROD_W     = 32;          // component product, 2^-30 units
	localparam int VEC_W      = 34;          // atan2 operand, 2^-30 units
	localparam int SC_W       = 32;          // clamped asin argument
	localparam int SQ_W       = 62;          // square root datapath
	localparam int SQRT_STEPS = 31;          // one root bit per step
	localparam int NORM_W     = 41;          // magnitude field, top bit is 2^40
	localparam int XW         = 45;          // CORDIC x/y width
	localparam int ZW         = 44;          // CORDIC angle, 2^-40 rad
	localparam int STAGES     = 32;          // CORDIC iterations
	localparam int RND_SH     = 27;          // 2^-40 -> 2^-13
	localparam int ANG_W      = ZW - RND_SH; // rounded Q3.13, unsaturated
	localparam int ATAN_LAT   = 3 + STAGES + 1;

	localparam int YAW_W   = 16;
	localparam int PITCH_W = 15;

	localparam logic signed [ANG_W-1:0] PI_Q13      = ANG_W'(25736);
	localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = ANG_W'(12868);

	typedef logic signed [ZW-1:0] arc_tab_t [STAGES+1];

	// shift-subtract quotient; only evaluated while the table is built
	function automatic longint unsigned cdiv(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 0;
		rem = 0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | 64'(num[b]);
			quo = quo << 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'd1;
			end
		end
		return quo;
	endfunction

	// Entries 0..STAGES-1: atan(2^-i) at 2^-40 rad; last entry: pi/2.
	// Built from integer arctangent series at 2^-60, rounded to 2^-40.
	function automatic arc_tab_t arc_table();
		arc_tab_t           t;
		longint             ser [STAGES+1];
		longint unsigned    n;
		longint unsigned    nn;
		longint unsigned    p;
		longint unsigned    k;
		longint             term;
		longint             acc;
		longint             qpi;
		for (int j = 0; j <= STAGES; j++) begin
			if (j == 0)
				n = 64'd5;
			else if (j == 1)
				n = 64'd239;
			else
				n = 64'd1 << (j - 1);
			p   = cdiv(64'd1 << 60, n);
			nn  = n * n;
			acc = 0;
			k   = 0;
			while (p != 0) begin
				term = longint'(cdiv(p, 2 * k + 1));
				if (k[0])
					acc = acc - term;
				else
					acc = acc + term;
				p = cdiv(p, nn);
				k = k + 1;
			end
			ser[j] = acc;
		end
		qpi  = 4 * ser[0] - ser[1];
		t[0] = ZW'((qpi + (64'sd1 <<< 19)) >>> 20);
		for (int i = 1; i < STAGES; i++)
			t[i] = ZW'((ser[i+1] + (64'sd1 <<< 19)) >>> 20);
		t[STAGES] = ZW'((2 * qpi + (64'sd1 <<< 19)) >>> 20);
		return t;
	endfunction

	localparam arc_tab_t ARC_TAB = arc_table();

endpackage

// ===== src/qte_atan2.sv =====
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined vectoring CORDIC: quadrant fold, two normalise stages,
// 32 iterations and a rounding stage. Q3.13 angle.
// ----------------------------------------------------------------------------
module qte_atan2 (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [qte_pkg::VEC_W-1:0]   vec_x,
	input  logic signed [qte_pkg::VEC_W-1:0]   vec_y,
	output logic signed [qte_pkg::ANG_W-1:0]   angle
);

	localparam int XW     = qte_pkg::XW;
	localparam int ZW     = qte_pkg::ZW;
	localparam int NW     = qte_pkg::NORM_W;
	localparam int STAGES = qte_pkg::STAGES;

	logic signed [XW-1:0] xe, ye, xr, yr;
	logic signed [ZW-1:0] z0;
	logic [NW-1:0]        mx, my;

	logic signed [XW-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic signed [ZW-1:0] z_s1, z_s2, z_s3;
	logic [NW-1:0]        m_s1, m_s2;
	logic                 zero_s1, zero_s2, zero_s3;

	logic signed [XW-1:0] x2, y2, x3, y3;
	logic [NW-1:0]        m2, m3;

	logic signed [XW-1:0] cx_s [STAGES+1];
	logic signed [XW-1:0] cy_s [STAGES+1];
	logic signed [ZW-1:0] cz_s [STAGES+1];
	logic                 cn_s [STAGES+1];

	logic signed [ZW-1:0]    zr;
	logic signed [qte_pkg::ANG_W-1:0] ang_s;

	// quadrant fold for negative x
	always_comb begin
		xe = XW'(vec_x);
		ye = XW'(vec_y);
		xr = xe;
		yr = ye;
		z0 = '0;
		if (vec_x[qte_pkg::VEC_W-1]) begin
			if (!vec_y[qte_pkg::VEC_W-1]) begin
				xr = ye;
				yr = -xe;
				z0 = qte_pkg::ARC_TAB[STAGES];
			end else begin
				xr = -ye;
				yr = xe;
				z0 = -qte_pkg::ARC_TAB[STAGES];
			end
		end
		mx = NW'(xr[XW-1] ? -xr : xr);
		my = NW'(yr[XW-1] ? -yr : yr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= xr;
			y_s1    <= yr;
			z_s1    <= z0;
			zero_s1 <= (vec_x == '0) && (vec_y == '0);
			m_s1    <= (mx > my) ? mx : my;
		end
	end

	// normalise: coarse shifts of 32, 16, 8
	always_comb begin
		m2 = m_s1;
		x2 = x_s1;
		y2 = y_s1;
		for (int k = 0; k < 3; k++) begin
			if ((m2 >> (NW - (32 >> k))) == '0) begin
				m2 = m2 << (32 >> k);
				x2 = x2 <<< (32 >> k);
				y2 = y2 <<< (32 >> k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= x2;
			y_s2    <= y2;
			z_s2    <= z_s1;
			m_s2    <= m2;
			zero_s2 <= zero_s1;
		end
	end

	// fine shifts of 4, 2, 1
	always_comb begin
		m3 = m_s2;
		x3 = x_s2;
		y3 = y_s2;
		for (int k = 0; k < 3; k++) begin
			if ((m3 >> (NW - (4 >> k))) == '0) begin
				m3 = m3 << (4 >> k);
				x3 = x3 <<< (4 >> k);
				y3 = y3 <<< (4 >> k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= x3;
			y_s3    <= y3;
			z_s3    <= z_s2;
			zero_s3 <= zero_s2;
		end
	end

	assign cx_s[0] = x_s3;
	assign cy_s[0] = y_s3;
	assign cz_s[0] = z_s3;
	assign cn_s[0] = zero_s3;

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		logic signed [XW-1:0] xs, ys;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][XW-1]) begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + qte_pkg::ARC_TAB[i];
				end else begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - qte_pkg::ARC_TAB[i];
				end
				cn_s[i+1] <= cn_s[i];
			end
		end
	end

	// round half up to Q3.13
	assign zr = cz_s[STAGES] + (ZW'(1) <<< (qte_pkg::RND_SH - 1));

	always_ff @(posedge clk) begin
		if (en)
			ang_s <= cn_s[STAGES] ? '0 : zr[ZW-1:qte_pkg::RND_SH];
	end

	assign angle = ang_s;

endmodule

// ===== src/quaternion_to_euler_angles_core.sv =====
// Throughput: one quaternion per cycle while no valid output is stalled; the
// 31-step root pipeline for pitch and the CORDIC units set the depth, never
// the rate. A stall on a valid output freezes the whole pipeline in place.
// Reset (arst_n low, asynchronous) clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Q1.15 quaternion in, yaw and roll in Q3.13, pitch in Q2.13 radians out,
// with a flag when the pitch sine had to be clamped to unit magnitude.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   quat_valid,
	output logic                                   quat_stall,
	input  logic signed [qte_pkg::IN_W-1:0]        q_first,
	input  logic signed [qte_pkg::IN_W-1:0]        q_second,
	input  logic signed [qte_pkg::IN_W-1:0]        q_third,
	input  logic signed [qte_pkg::IN_W-1:0]        q_fourth,
	output logic                                   euler_valid,
	input  logic                                   euler_stall,
	output logic signed [qte_pkg::YAW_W-1:0]       yaw_angle,
	output logic signed [qte_pkg::PITCH_W-1:0]     pitch_angle,
	output logic signed [qte_pkg::YAW_W-1:0]       roll_angle,
	output logic                                   pitch_clamped
);

	localparam int PW       = qte_pkg::PROD_W;
	localparam int VW       = qte_pkg::VEC_W;
	localparam int SW       = qte_pkg::SC_W;
	localparam int QW       = qte_pkg::SQ_W;
	localparam int AW       = qte_pkg::ANG_W;
	localparam int NSTEP    = qte_pkg::SQRT_STEPS;
	localparam int SQRT_LAT = 2 + NSTEP;
	localparam int FLAG_LAT = SQRT_LAT + qte_pkg::ATAN_LAT;
	localparam int PIPE_LAT = 2 + FLAG_LAT + 1;

	localparam logic signed [VW-1:0] ONE_Q30 = VW'(64'sd1 <<< 30);

	logic en;
	logic [PIPE_LAT-1:0] vld_s;

	logic signed [PW-1:0] aa_s1, bb_s1, cc_s1, dd_s1, ab_s1, cd_s1, bc_s1, ad_s1,
	                      ac_s1, bd_s1;
	logic signed [VW-1:0] yaw_y_s2, yaw_x_s2, roll_y_s2, roll_x_s2;
	logic signed [SW-1:0] sc_s2;
	logic                 flag_s2;
	logic signed [VW-1:0] s_full;
	logic signed [SW-1:0] sc_c;
	logic                 flag_c;

	logic [QW-1:0] sq_s3;
	logic [QW-1:0] rad_s4;
	logic [QW-1:0] rn_s [NSTEP+1];
	logic [QW-1:0] rr_s [NSTEP+1];

	logic signed [SW-1:0] s_dly [SQRT_LAT];
	logic signed [AW-1:0] yaw_dly [SQRT_LAT];
	logic signed [AW-1:0] roll_dly [SQRT_LAT];
	logic                 flag_dly [FLAG_LAT];

	logic signed [AW-1:0] yaw_raw, roll_raw, pitch_raw;
	logic signed [AW-1:0] yaw_sat, roll_sat, roll_sh, pitch_sat;
	logic signed [VW-1:0] pitch_y, pitch_x;

	assign en         = !(euler_valid && euler_stall);
	assign quat_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], quat_valid};
		end
	end

	assign euler_valid = vld_s[PIPE_LAT-1];

	// products, 2^-30 units
	always_ff @(posedge clk) begin
		if (en) begin
			aa_s1 <= q_first * q_first;
			bb_s1 <= q_second * q_second;
			cc_s1 <= q_third * q_third;
			dd_s1 <= q_fourth * q_fourth;
			ab_s1 <= q_first * q_second;
			cd_s1 <= q_third * q_fourth;
			bc_s1 <= q_second * q_third;
			ad_s1 <= q_first * q_fourth;
			ac_s1 <= q_first * q_third;
			bd_s1 <= q_second * q_fourth;
		end
	end

	// asin argument with clamp to unit magnitude
	always_comb begin
		s_full = (VW'(ac_s1) - VW'(bd_s1)) <<< 1;
		flag_c = 1'b0;
		sc_c   = SW'(s_full);
		if (s_full > ONE_Q30) begin
			sc_c   = SW'(ONE_Q30);
			flag_c = 1'b1;
		end else if (s_full < -ONE_Q30) begin
			sc_c   = SW'(-ONE_Q30);
			flag_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_y_s2  <= (VW'(cd_s1) + VW'(ab_s1)) <<< 1;
			yaw_x_s2  <= VW'(aa_s1) - VW'(bb_s1) - VW'(cc_s1) + VW'(dd_s1);
			roll_y_s2 <= (VW'(bc_s1) + VW'(ad_s1)) <<< 1;
			roll_x_s2 <= VW'(aa_s1) + VW'(bb_s1) - VW'(cc_s1) - VW'(dd_s1);
			sc_s2     <= sc_c;
			flag_s2   <= flag_c;
		end
	end

	// cosine of pitch: floor(sqrt(2^60 - s^2))
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3  <= QW'(unsigned'(64'(sc_s2) * 64'(sc_s2)));
			rad_s4 <= (QW'(1) << 60) - sq_s3;
		end
	end

	assign rn_s[0] = rad_s4;
	assign rr_s[0] = '0;

	for (genvar j = 0; j < NSTEP; j++) begin : g_root
		localparam logic [QW-1:0] BIT = QW'(1) << (2 * (NSTEP - 1 - j));
		logic [QW-1:0] trial;
		assign trial = rr_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn_s[j] >= trial) begin
					rn_s[j+1] <= rn_s[j] - trial;
					rr_s[j+1] <= (rr_s[j] >> 1) + BIT;
				end else begin
					rn_s[j+1] <= rn_s[j];
					rr_s[j+1] <= rr_s[j] >> 1;
				end
			end
		end
	end

	// yaw and roll CORDICs run early; their results wait for pitch
	qte_atan2 u_yaw (
		.clk   (clk),
		.en    (en),
		.vec_x (yaw_x_s2),
		.vec_y (yaw_y_s2),
		.angle (yaw_raw)
	);

	qte_atan2 u_roll (
		.clk   (clk),
		.en    (en),
		.vec_x (roll_x_s2),
		.vec_y (roll_y_s2),
		.angle (roll_raw)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			s_dly[0]    <= sc_s2;
			yaw_dly[0]  <= yaw_raw;
			roll_dly[0] <= roll_raw;
			flag_dly[0] <= flag_s2;
			for (int i = 1; i < SQRT_LAT; i++) begin
				s_dly[i]    <= s_dly[i-1];
				yaw_dly[i]  <= yaw_dly[i-1];
				roll_dly[i] <= roll_dly[i-1];
			end
			for (int i = 1; i < FLAG_LAT; i++)
				flag_dly[i] <= flag_dly[i-1];
		end
	end

	assign pitch_y = VW'(s_dly[SQRT_LAT-1]);
	assign pitch_x = VW'({1'b0, rr_s[NSTEP][NSTEP-1:0]});

	qte_atan2 u_pitch (
		.clk   (clk),
		.en    (en),
		.vec_x (pitch_x),
		.vec_y (pitch_y),
		.angle (pitch_raw)
	);

	// saturation and the pi shift on roll
	always_comb begin
		yaw_sat = yaw_dly[SQRT_LAT-1];
		if (yaw_sat > qte_pkg::PI_Q13)
			yaw_sat = qte_pkg::PI_Q13;
		else if (yaw_sat < -qte_pkg::PI_Q13)
			yaw_sat = -qte_pkg::PI_Q13;

		roll_sat = roll_dly[SQRT_LAT-1];
		if (roll_sat > qte_pkg::PI_Q13)
			roll_sat = qte_pkg::PI_Q13;
		else if (roll_sat < -qte_pkg::PI_Q13)
			roll_sat = -qte_pkg::PI_Q13;
		roll_sh = roll_sat[AW-1] ? roll_sat + qte_pkg::PI_Q13
		                         : roll_sat - qte_pkg::PI_Q13;

		pitch_sat = pitch_raw;
		if (pitch_sat > qte_pkg::HALF_PI_Q13)
			pitch_sat = qte_pkg::HALF_PI_Q13;
		else if (pitch_sat < -qte_pkg::HALF_PI_Q13)
			pitch_sat = -qte_pkg::HALF_PI_Q13;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_angle     <= yaw_sat[qte_pkg::YAW_W-1:0];
			roll_angle    <= roll_sh[qte_pkg::YAW_W-1:0];
			pitch_angle   <= pitch_sat[qte_pkg::PITCH_W-1:0];
			pitch_clamped <= flag_dly[FLAG_LAT-1];
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for quaternion_to_euler_angles_core. Quaternions are sent through
// the valid/stall input channel, with an independent bit-true model of the
// CORDIC yaw, pitch and roll path predicting each angle transaction. The
// output channel is stalled at random and for long holds; every transaction
// is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSTAGE    = 32;
	localparam longint PI13  = 25736;
	localparam longint HPI13 = 12868;
	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		logic signed [15:0] yaw;
		logic signed [14:0] pitch;
		logic signed [15:0] roll;
		logic               clamped;
	} angles_t;

	logic                 clk;
	logic                 arst_n;
	logic                 quat_valid;
	logic                 quat_stall;
	logic signed [15:0]   q_first, q_second, q_third, q_fourth;
	logic                 euler_valid;
	logic                 euler_stall;
	logic signed [15:0]   yaw_angle;
	logic signed [14:0]   pitch_angle;
	logic signed [15:0]   roll_angle;
	logic                 pitch_clamped;

	angles_t angles_q[$];
	longint  atan_lut[NSTAGE];
	longint  half_pi_q40;
	int      n_errors;
	int      hold_cycles;
	int      stall_pct;
	int      long_gaps;

	quaternion_to_euler_angles_core uut (
		.clk(clk), .arst_n(arst_n),
		.quat_valid(quat_valid), .quat_stall(quat_stall),
		.q_first(q_first), .q_second(q_second), .q_third(q_third), .q_fourth(q_fourth),
		.euler_valid(euler_valid), .euler_stall(euler_stall),
		.yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
		.pitch_clamped(pitch_clamped)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// atan(1/n) at 2^-60 by the alternating series
	function automatic longint arctan_inv(longint unsigned n);
		longint unsigned p;
		longint unsigned k;
		longint          acc;
		p = (64'd1 << 60) / n;
		k = 0;
		acc = 0;
		while (p != 0) begin
			if (k[0])
				acc -= longint'(p / (2 * k + 1));
			else
				acc += longint'(p / (2 * k + 1));
			p = p / (n * n);
			k++;
		end
		return acc;
	endfunction

	function automatic void fill_atan_lut();
		longint qpi;
		qpi = 4 * arctan_inv(5) - arctan_inv(239);
		atan_lut[0] = (qpi + (64'sd1 <<< 19)) >>> 20;
		half_pi_q40 = (2 * qpi + (64'sd1 <<< 19)) >>> 20;
		for (int i = 1; i < NSTAGE; i++)
			atan_lut[i] = (arctan_inv(64'd1 << i) + (64'sd1 <<< 19)) >>> 20;
	endfunction

	function automatic longint clip(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint cordic_atan2(longint y, longint x);
		longint z, t, m, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = half_pi_q40;
			end else begin
				x = -y; y = t; z = -half_pi_q40;
			end
		end
		m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
		while (m < (64'sd1 <<< 40)) begin
			x *= 2; y *= 2; m *= 2;
		end
		for (int i = 0; i < NSTAGE; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_lut[i];
			end else begin
				x -= ys; y += xs; z -= atan_lut[i];
			end
		end
		return clip((z + (64'sd1 <<< 26)) >>> 27, PI13);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic angles_t quat_to_euler(longint a, longint b, longint c, longint d);
		angles_t r;
		longint  s, rl;
		r.yaw = 16'(cordic_atan2(2 * (c * d + a * b), a * a - b * b - c * c + d * d));
		s = 2 * (a * c - b * d);
		r.clamped = 1'b0;
		if (s > (64'sd1 <<< 30)) begin
			s = 64'sd1 <<< 30; r.clamped = 1'b1;
		end else if (s < -(64'sd1 <<< 30)) begin
			s = -(64'sd1 <<< 30); r.clamped = 1'b1;
		end
		r.pitch = 15'(clip(cordic_atan2(s,
			longint'(int_sqrt((64'd1 << 60) - longint'(s * s)))), HPI13));
		rl = cordic_atan2(2 * (b * c + a * d), a * a + b * b - c * c - d * d);
		rl = (rl >= 0) ? rl - PI13 : rl + PI13;
		r.roll = 16'(rl);
		return r;
	endfunction

	// input side: predict on every accepted quaternion
	always @(posedge clk) begin
		if (arst_n && quat_valid && !quat_stall)
			angles_q.push_back(quat_to_euler(q_first, q_second, q_third, q_fourth));
	end

	// output side: compare against the oldest prediction
	always @(posedge clk) begin
		angles_t e;
		if (arst_n && euler_valid && !euler_stall) begin
			if (angles_q.size() == 0) begin
				$error("unexpected angle transaction");
				n_errors++;
			end else begin
				e = angles_q.pop_front();
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle exp %0d got %0d", e.yaw, yaw_angle);
					n_errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle exp %0d got %0d", e.pitch, pitch_angle);
					n_errors++;
				end
				if (roll_angle !== e.roll) begin
					$error("roll_angle exp %0d got %0d", e.roll, roll_angle);
					n_errors++;
				end
				if (pitch_clamped !== e.clamped) begin
					$error("pitch_clamped exp %0d got %0d", e.clamped, pitch_clamped);
					n_errors++;
				end
			end
		end
	end

	// receiver stall: random, with long holds counted here
	initial begin
		euler_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				euler_stall = 1'b1;
				hold_cycles--;
			end else if ($urandom_range(0, 299) == 0) begin
				hold_cycles = $urandom_range(20, 80);
				euler_stall = 1'b1;
			end else begin
				euler_stall = ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((quat_valid && !quat_stall) || (euler_valid && !euler_stall))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("quaternion_to_euler_angles_core verification failed");
				$finish;
			end
		end
	end

	task automatic send_quat(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, bit gaps);
		int gap;
		@(negedge clk);
		q_first = a; q_second = b; q_third = c; q_fourth = d;
		quat_valid = 1'b1;
		@(posedge clk);
		while (quat_stall)
			@(posedge clk);
		gap = 0;
		if (gaps) begin
			if ($urandom_range(0, 99) < 3)
				gap = $urandom_range(15, 60);
			else if ($urandom_range(0, 99) < 40)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			@(negedge clk);
			quat_valid = 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// drop valid first so the last quaternion is not offered again
	task automatic wait_drained();
		@(negedge clk);
		quat_valid = 1'b0;
		while (angles_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] rand_component();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return 16'($signed($urandom_range(0, 511)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		stall_pct = 0;
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);        // zero vectors
		send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 0);        // identity
		send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 0);        // x<0, y=0 -> +pi
		send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 0);
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 0);
		send_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000, 0);
		send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 0);        // sine above one
		send_quat(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 0);        // sine below minus one
		send_quat(16'h8000, 16'h0000, 16'h8000, 16'h0000, 0);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
		send_quat(16'h5A82, 16'h0000, 16'h5A82, 16'h0000, 0);        // pitch near +pi/2
		send_quat(16'h5A82, 16'h5A82, 16'h0000, 16'h0000, 0);
		send_quat(16'h5A82, 16'h0000, 16'h0000, 16'h5A82, 0);
		send_quat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 0);
		send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000, 0);
		send_quat(16'hC000, 16'h4000, 16'hC000, 16'h4000, 0);
		send_quat(16'h0000, 16'h0000, 16'h0001, 16'h0000, 0);
		send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000, 0);
		wait_drained();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0)
				stall_pct = (i % 400 == 0) ? 0 : $urandom_range(10, 60);
			send_quat(rand_component(), rand_component(), rand_component(),
				rand_component(), 1);
		end
		wait_drained();
	endtask

	// receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		stall_pct = 0;
		@(negedge clk);
		hold_cycles = 300;
		for (int i = 0; i < 150; i++)
			send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 0);
		wait_drained();
	endtask

	// sender pauses for a full drain between bursts
	task automatic test_pause_drain();
		stall_pct = 30;
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 10; i++)
				send_quat(rand_component(), rand_component(), rand_component(),
					rand_component(), 1);
			@(negedge clk);
			quat_valid = 1'b0;
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		quat_valid = 1'b0;
		q_first = '0; q_second = '0; q_third = '0; q_fourth = '0;
		n_errors = 0;
		hold_cycles = 0;
		stall_pct = 0;
		fill_atan_lut();
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_pause_drain();
		test_random(1500);
		@(negedge clk);
		quat_valid = 1'b0;
		wait_drained();
		repeat (150)
			@(posedge clk);
		if (n_errors == 0)
			$display("quaternion_to_euler_angles_core verification clean");
		else
			$display("quaternion_to_euler_angles_core verification failed");
		$finish;
	end

endmodule
